// ===== rtl/core/de_pkg.sv =====
// Package with shared constants and types for the divisor enumerator.
package de_pkg;
   localparam int TableSize = 1024;
   localparam int AddrW = $clog2(TableSize);
   localparam int ValW = 10;
   localparam int PosW = 5;
   localparam int TotW = 6;
   localparam int MaxOut = 32;
   localparam int MaxPrimes = 16;
   localparam int PrimeIdxW = $clog2(MaxPrimes);
   // Wide enough for the largest exponent of any value below the table size, plus one.
   localparam int ExpW = $clog2(AddrW);

   typedef struct packed {
      logic [ValW-1:0] divisor;
      logic [PosW-1:0] position;
      logic [TotW-1:0] total;
      logic            is_last;
   } rsp_type;
endpackage

// ===== rtl/core/de_if.sv =====
// Valid/ready channel interfaces for the divisor enumerator.
interface de_req_if import de_pkg::*; (input logic clock);
   logic            valid;
   logic            ready;
   logic [ValW-1:0] value;
   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface de_rsp_if import de_pkg::*; (input logic clock);
   logic            valid;
   logic            ready;
   logic [ValW-1:0] divisor;
   logic [PosW-1:0] position;
   logic [TotW-1:0] total;
   logic            is_last;
   modport source (output valid, output divisor, output position, output total,
                   output is_last, input ready);
   modport sink (input valid, input divisor, input position, input total,
                 input is_last, output ready);
endinterface

// ===== rtl/core/de_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
module de_divider import de_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [AddrW-1:0] dividend,
   input  logic [AddrW-1:0] divisor,
   output logic            done,
   output logic [AddrW-1:0] quotient
);
   localparam int CntW = $clog2(AddrW + 1);
   logic [AddrW-1:0] quo_ff, quo_in;
   logic [AddrW:0]   rem_ff, rem_in;
   logic [AddrW-1:0] dsr_ff, dsr_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [AddrW:0]   trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[AddrW-1:0], quo_ff[AddrW-1]};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = CntW'(AddrW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[AddrW-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in[0] = 1'b1;
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff - CntW'(1);
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;
endmodule

// ===== rtl/core/divisor_enumerator.sv =====
// Top level of the divisor enumerator: sieve, factorization and list emission.
//
//  Channel | Dir | Beat contents
//  req     | in  | value
//  rsp     | out | divisor, position, total, is_last
//
// After reset a clearing pass writes every table entry, then the sieve reads and
// checks each candidate and, for each prime found, writes that prime to each of its
// multiples; req.ready stays low until then.
// A value is then accepted; each prime factor, counted with multiplicity, takes a
// table read, a check and a pass through the shared divider, plus one final read.
// The list is then built per distinct prime, exponent level and built divisor,
// and emitted one rsp beat at a time. A stalled rsp beat holds the emit loop, and
// req.ready stays low until the last beat is taken.
module divisor_enumerator import de_pkg::*; (
   input logic clock,
   input logic reset,
   de_req_if.sink   req,
   de_rsp_if.source rsp
);
   typedef enum logic [9:0] {
      S_CLEAR   = 10'b0000000001,
      S_SV_RD   = 10'b0000000010,
      S_SV_CHK  = 10'b0000000100,
      S_SV_MARK = 10'b0000001000,
      S_IDLE    = 10'b0000010000,
      S_FA_RD   = 10'b0000100000,
      S_FA_CHK  = 10'b0001000000,
      S_FA_DIV  = 10'b0010000000,
      S_BUILD   = 10'b0100000000,
      S_EMIT    = 10'b1000000000
   } state_type;

   localparam int CntW = AddrW + 1;

   state_type state_ff, state_in;
   logic [AddrW-1:0] lpf_mem [TableSize];
   logic [AddrW-1:0] lpf_rd_ff;
   logic [AddrW-1:0] lpf_ra, lpf_wa, lpf_wd;
   logic             lpf_we;

   logic [CntW-1:0]  i_ff, i_in, j_ff, j_in;
   logic [AddrW-1:0] p_ff, p_in, k_ff, k_in;

   logic [ValW-1:0]  list_ff [MaxOut];
   logic [ValW-1:0]  primes_ff [MaxPrimes];
   logic [ExpW-1:0]  exps_ff [MaxPrimes];
   logic [PrimeIdxW:0] np_ff, np_in, np_next;
   logic [ExpW-1:0]  e_ff, e_in;
   logic [TotW-1:0]  len_ff, len_in, base_ff, base_in;
   logic [TotW-1:0]  d_ff, d_in;
   logic [ExpW-1:0]  jj_ff, jj_in;
   logic [PrimeIdxW:0] idx_ff, idx_in;
   logic [ValW-1:0]  mult_ff, mult_in;
   logic [PosW-1:0]  pos_ff, pos_in;
   logic             list_we;
   logic             prime_we;
   logic [ValW-1:0]  cur_prime;
   logic [ExpW-1:0]  cur_exp;
   logic [ValW-1:0]  prod, next_mult;
   logic             last_beat;

   logic             div_start, div_done;
   logic [AddrW-1:0] div_a, div_b, div_q;

   de_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_a),
      .divisor(div_b), .done(div_done), .quotient(div_q)
   );

   always_ff @(posedge clock) begin
      if (lpf_we) lpf_mem[lpf_wa] <= lpf_wd;
      lpf_rd_ff <= lpf_mem[lpf_ra];
   end

   assign cur_prime = primes_ff[idx_ff[PrimeIdxW-1:0] - PrimeIdxW'(1)];
   assign cur_exp = exps_ff[idx_ff[PrimeIdxW-1:0] - PrimeIdxW'(1)];
   assign prod = ValW'((2*ValW)'(list_ff[d_ff[PosW-1:0]]) * (2*ValW)'(mult_ff));
   assign next_mult = ValW'((2*ValW)'(mult_ff) * (2*ValW)'(cur_prime));
   assign np_next = (e_ff != '0) ? np_ff + (PrimeIdxW+1)'(1) : np_ff;
   assign last_beat = (TotW'(pos_ff) + TotW'(1) == len_ff);

   always_comb begin
      state_in = state_ff;
      i_in = i_ff; j_in = j_ff; p_in = p_ff; k_in = k_ff;
      np_in = np_ff; e_in = e_ff; len_in = len_ff; base_in = base_ff; d_in = d_ff;
      jj_in = jj_ff; idx_in = idx_ff; mult_in = mult_ff; pos_in = pos_ff;
      lpf_ra = k_ff; lpf_wa = i_ff[AddrW-1:0]; lpf_wd = '0; lpf_we = 1'b0;
      div_start = 1'b0; div_a = k_ff; div_b = p_ff;
      list_we = 1'b0; prime_we = 1'b0;
      req.ready = 1'b0;
      rsp.valid = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            // Entries zero and one hold one; every other entry starts empty.
            lpf_we = 1'b1;
            lpf_wd = (i_ff < CntW'(2)) ? AddrW'(1) : '0;
            if (i_ff == CntW'(TableSize - 1)) begin
               i_in = CntW'(2);
               state_in = S_SV_RD;
            end else begin
               i_in = i_ff + CntW'(1);
            end
         end
         S_SV_RD: begin
            lpf_ra = i_ff[AddrW-1:0];
            if (i_ff == CntW'(TableSize)) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_SV_CHK;
            end
         end
         S_SV_CHK: begin
            // An entry still empty when reached has no smaller prime factor.
            if (lpf_rd_ff == '0) begin
               p_in = i_ff[AddrW-1:0];
               j_in = i_ff;
               state_in = S_SV_MARK;
            end else begin
               i_in = i_ff + CntW'(1);
               state_in = S_SV_RD;
            end
         end
         S_SV_MARK: begin
            // Primes come in ascending order, so the last prime written is the largest.
            if (j_ff >= CntW'(TableSize)) begin
               i_in = i_ff + CntW'(1);
               state_in = S_SV_RD;
            end else begin
               lpf_we = 1'b1;
               lpf_wa = j_ff[AddrW-1:0];
               lpf_wd = p_ff;
               j_in = j_ff + CntW'(p_ff);
            end
         end
         S_IDLE: begin
            req.ready = 1'b1;
            if (req.valid && req.value != '0 && 32'(req.value) < 32'(TableSize)) begin
               k_in = AddrW'(req.value);
               np_in = '0;
               e_in = '0;
               p_in = '0;
               state_in = S_FA_RD;
            end
         end
         S_FA_RD: begin
            lpf_ra = k_ff;
            if (k_ff < AddrW'(2)) begin
               prime_we = (e_ff != '0);
               np_in = np_next;
               idx_in = np_next;
               len_in = TotW'(1);
               jj_in = '0;
               state_in = S_BUILD;
            end else begin
               state_in = S_FA_CHK;
            end
         end
         S_FA_CHK: begin
            if (e_ff != '0 && lpf_rd_ff == p_ff) begin
               div_start = 1'b1;
               state_in = S_FA_DIV;
            end else begin
               prime_we = (e_ff != '0);
               np_in = np_next;
               if (np_next == (PrimeIdxW+1)'(MaxPrimes)) begin
                  idx_in = np_next;
                  len_in = TotW'(1);
                  jj_in = '0;
                  state_in = S_BUILD;
               end else begin
                  p_in = lpf_rd_ff;
                  e_in = '0;
                  div_b = lpf_rd_ff;
                  div_start = 1'b1;
                  state_in = S_FA_DIV;
               end
            end
         end
         S_FA_DIV: begin
            if (div_done) begin
               k_in = div_q;
               e_in = e_ff + ExpW'(1);
               state_in = S_FA_RD;
            end
         end
         S_BUILD: begin
            // jj = current exponent, d walks the base list.
            if (idx_ff == '0) begin
               pos_in = '0;
               state_in = S_EMIT;
            end else if (jj_ff == '0) begin
               jj_in = ExpW'(1);
               base_in = len_ff;
               d_in = '0;
               mult_in = cur_prime;
            end else if (jj_ff > cur_exp) begin
               idx_in = idx_ff - (PrimeIdxW+1)'(1);
               jj_in = '0;
            end else if (d_ff < base_ff && len_ff < TotW'(MaxOut)) begin
               list_we = 1'b1;
               len_in = len_ff + TotW'(1);
               d_in = d_ff + TotW'(1);
            end else begin
               d_in = '0;
               jj_in = jj_ff + ExpW'(1);
               mult_in = next_mult;
            end
         end
         S_EMIT: begin
            rsp.valid = 1'b1;
            if (rsp.ready) begin
               pos_in = pos_ff + PosW'(1);
               if (last_beat) state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         i_ff <= '0;
      end else begin
         state_ff <= state_in;
         i_ff <= i_in;
      end
      j_ff <= j_in; p_ff <= p_in; k_ff <= k_in;
      np_ff <= np_in; e_ff <= e_in; len_ff <= len_in; base_ff <= base_in;
      d_ff <= d_in; jj_ff <= jj_in; idx_ff <= idx_in; mult_ff <= mult_in;
      pos_ff <= pos_in;
      if (state_ff == S_IDLE) list_ff[0] <= ValW'(1);
      if (list_we) list_ff[len_ff[PosW-1:0]] <= prod;
      if (prime_we) begin
         primes_ff[np_ff[PrimeIdxW-1:0]] <= ValW'(p_ff);
         exps_ff[np_ff[PrimeIdxW-1:0]] <= e_ff;
      end
   end

   assign rsp.divisor = list_ff[pos_ff];
   assign rsp.position = pos_ff;
   assign rsp.total = len_ff;
   assign rsp.is_last = last_beat;
endmodule

// ===== rtl/core/de_checker.sv =====
// Port-level checker for the divisor enumerator, bound to the top level.
module de_checker import de_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input logic [ValW-1:0] rsp_divisor,
   input logic [PosW-1:0] rsp_position,
   input logic [TotW-1:0] rsp_total,
   input logic            rsp_is_last
);
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while emitting");
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_last == (TotW'(rsp_position) + TotW'(1) == rsp_total)))
      else $error("is_last mismatch");
   a_first_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_position == '0) |-> rsp_divisor == ValW'(1))
      else $error("first divisor not one");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_divisor))
      else $error("stalled beat changed");
endmodule

bind divisor_enumerator de_checker u_de_checker (
   .clock(clock), .reset(reset), .req_ready(req.ready), .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready), .rsp_divisor(rsp.divisor), .rsp_position(rsp.position),
   .rsp_total(rsp.total), .rsp_is_last(rsp.is_last)
);
